FILE: rtl/core/arbb_pkg.sv
// Types, constants and fixed-point helpers shared by the affine bounding box block.
package arbb_pkg;

  // Number format: signed fixed point, CoordBits wide with FracBits fraction bits.
  localparam int unsigned CoordBits  = 32;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned ProdBits   = 2 * CoordBits;
  localparam int unsigned ScaledBits = ProdBits - FracBits;
  localparam int unsigned WideBits   = CoordBits + 2;
  localparam int unsigned CfgIdxBits = 3;

  // Register stages from the input word to the output register.
  localparam int unsigned NumStages  = 7;

  typedef logic signed [CoordBits-1:0]  coord_t;
  typedef logic        [CoordBits-2:0]  extent_t;
  typedef logic signed [WideBits-1:0]   wide_t;
  typedef logic signed [ProdBits-1:0]   prod_t;
  typedef logic signed [ScaledBits-1:0] scaled_t;

  localparam coord_t CoordMax = coord_t'({1'b0, {(CoordBits-1){1'b1}}});
  localparam coord_t CoordMin = coord_t'({1'b1, {(CoordBits-1){1'b0}}});
  localparam coord_t CoefOne  = coord_t'(1) << FracBits;

  // Configuration register indexes.
  typedef enum logic [CfgIdxBits-1:0] {
    CfgCoefXx  = CfgIdxBits'(0),
    CfgCoefXy  = CfgIdxBits'(1),
    CfgOffsetX = CfgIdxBits'(2),
    CfgCoefYx  = CfgIdxBits'(3),
    CfgCoefYy  = CfgIdxBits'(4),
    CfgOffsetY = CfgIdxBits'(5)
  } cfg_idx_e;

  // Input word: one rectangle.
  typedef struct packed {
    coord_t rect_left;
    coord_t rect_top;
    coord_t rect_width;
    coord_t rect_height;
  } rect_t;

  // Output word: the bounding box of the mapped corners.
  typedef struct packed {
    coord_t  box_left;
    coord_t  box_top;
    extent_t box_width;
    extent_t box_height;
  } box_t;

  // Advance strobes for the three stages of the extent reduction.
  typedef struct packed {
    logic pair;
    logic total;
    logic span;
  } ext_adv_t;

  // Sign-extend a coordinate to the width used for sums.
  function automatic wide_t widen(input coord_t a);
    return wide_t'(a);
  endfunction

  // Saturate a sum of up to three coordinates to the coordinate range.
  function automatic coord_t sat_coord(input wide_t v);
    if (v[WideBits-1:CoordBits-1] == {3{v[CoordBits-1]}}) begin
      return v[CoordBits-1:0];
    end else if (v[WideBits-1]) begin
      return CoordMin;
    end else begin
      return CoordMax;
    end
  endfunction

  // Exact signed product of two coordinates.
  function automatic prod_t mul_full(input coord_t a, input coord_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

  // Drop the fraction bits (rounding toward minus infinity) and saturate.
  function automatic coord_t scale_sat(input prod_t p);
    scaled_t q;
    q = p[ProdBits-1:FracBits];
    if (q[ScaledBits-1:CoordBits-1] == {(ScaledBits-CoordBits+1){q[CoordBits-1]}}) begin
      return q[CoordBits-1:0];
    end else if (q[ScaledBits-1]) begin
      return CoordMin;
    end else begin
      return CoordMax;
    end
  endfunction

endpackage

FILE: rtl/core/arbb_extent.sv
// Min/max reduction over four mapped corners and the saturated box extent.
module arbb_extent (
  input  logic                          clk_i,
  input  arbb_pkg::ext_adv_t            adv_i,
  input  arbb_pkg::coord_t [3:0]        px_i,
  input  arbb_pkg::coord_t [3:0]        py_i,
  output arbb_pkg::box_t                box_o
);

  arbb_pkg::coord_t [1:0] minx_q, maxx_q, miny_q, maxy_q;
  arbb_pkg::coord_t       minx_tot_q, maxx_tot_q, miny_tot_q, maxy_tot_q;
  arbb_pkg::box_t         box_q, box_d;

  logic signed [arbb_pkg::CoordBits:0] dx, dy;

  // First level: pairs of corners that share the same x input value.
  always_ff @(posedge clk_i) begin
    if (adv_i.pair) begin
      for (int k = 0; k < 2; k++) begin
        minx_q[k] <= (px_i[2*k] < px_i[2*k+1]) ? px_i[2*k] : px_i[2*k+1];
        maxx_q[k] <= (px_i[2*k] > px_i[2*k+1]) ? px_i[2*k] : px_i[2*k+1];
        miny_q[k] <= (py_i[2*k] < py_i[2*k+1]) ? py_i[2*k] : py_i[2*k+1];
        maxy_q[k] <= (py_i[2*k] > py_i[2*k+1]) ? py_i[2*k] : py_i[2*k+1];
      end
    end
  end

  // Second level: overall least and greatest per axis.
  always_ff @(posedge clk_i) begin
    if (adv_i.total) begin
      minx_tot_q <= (minx_q[0] < minx_q[1]) ? minx_q[0] : minx_q[1];
      maxx_tot_q <= (maxx_q[0] > maxx_q[1]) ? maxx_q[0] : maxx_q[1];
      miny_tot_q <= (miny_q[0] < miny_q[1]) ? miny_q[0] : miny_q[1];
      maxy_tot_q <= (maxy_q[0] > maxy_q[1]) ? maxy_q[0] : maxy_q[1];
    end
  end

  // The difference is never negative, so only the top magnitude bit can overflow.
  always_comb begin
    dx = (arbb_pkg::CoordBits+1)'(maxx_tot_q) - (arbb_pkg::CoordBits+1)'(minx_tot_q);
    dy = (arbb_pkg::CoordBits+1)'(maxy_tot_q) - (arbb_pkg::CoordBits+1)'(miny_tot_q);
    box_d.box_left   = minx_tot_q;
    box_d.box_top    = miny_tot_q;
    box_d.box_width  = dx[arbb_pkg::CoordBits-1] ? '1 : dx[arbb_pkg::CoordBits-2:0];
    box_d.box_height = dy[arbb_pkg::CoordBits-1] ? '1 : dy[arbb_pkg::CoordBits-2:0];
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (adv_i.span) begin
      box_q <= box_d;
    end
  end

  assign box_o = box_q;

endmodule

FILE: rtl/core/affine_rect_bounding_box.sv
// Throughput: one word per cycle; the seven-stage pipeline only holds while the
// output stalls, and empty stages are filled even then.
// Reset: clears every stage valid bit and loads the identity transform
// (unit diagonal coefficients, zero offsets).
module affine_rect_bounding_box (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [arbb_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [arbb_pkg::CoordBits-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  arbb_pkg::rect_t                     in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output arbb_pkg::box_t                      out_data_o
);

  localparam int unsigned StgCorner = 0;
  localparam int unsigned StgMul    = 1;
  localparam int unsigned StgScale  = 2;
  localparam int unsigned StgSum    = 3;
  localparam int unsigned StgPair   = 4;
  localparam int unsigned StgTotal  = 5;
  localparam int unsigned StgSpan   = 6;

  arbb_pkg::coord_t coef_xx_q, coef_xy_q, offset_x_q, coef_yx_q, coef_yy_q, offset_y_q;

  logic [arbb_pkg::NumStages-1:0] vld_q, vld_d, adv;

  arbb_pkg::coord_t       x0_q, y0_q, x1_q, y1_q;
  arbb_pkg::prod_t  [7:0] prod_q;
  arbb_pkg::coord_t [7:0] term_q;
  arbb_pkg::coord_t [3:0] px_q, py_q;
  arbb_pkg::ext_adv_t     ext_adv;

  // Configuration registers; indexes outside the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_xx_q  <= arbb_pkg::CoefOne;
      coef_xy_q  <= '0;
      offset_x_q <= '0;
      coef_yx_q  <= '0;
      coef_yy_q  <= arbb_pkg::CoefOne;
      offset_y_q <= '0;
    end else if (cfg_we_i) begin
      case (arbb_pkg::cfg_idx_e'(cfg_idx_i))
        arbb_pkg::CfgCoefXx:  coef_xx_q  <= cfg_wdata_i;
        arbb_pkg::CfgCoefXy:  coef_xy_q  <= cfg_wdata_i;
        arbb_pkg::CfgOffsetX: offset_x_q <= cfg_wdata_i;
        arbb_pkg::CfgCoefYx:  coef_yx_q  <= cfg_wdata_i;
        arbb_pkg::CfgCoefYy:  coef_yy_q  <= cfg_wdata_i;
        arbb_pkg::CfgOffsetY: offset_y_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // A stage advances when it is empty or the stage after it advances.
  always_comb begin
    adv[arbb_pkg::NumStages-1] = !vld_q[arbb_pkg::NumStages-1] || !out_stall_i;
    for (int k = arbb_pkg::NumStages - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
    vld_d = {vld_q[arbb_pkg::NumStages-2:0], in_valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < arbb_pkg::NumStages; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  assign in_stall_o  = !adv[StgCorner];
  assign out_valid_o = vld_q[StgSpan];

  // Near and far corners; the far corner is saturated to the coordinate range.
  always_ff @(posedge clk_i) begin
    if (adv[StgCorner]) begin
      x0_q <= in_data_i.rect_left;
      y0_q <= in_data_i.rect_top;
      x1_q <= arbb_pkg::sat_coord(arbb_pkg::widen(in_data_i.rect_left)
                                  + arbb_pkg::widen(in_data_i.rect_width));
      y1_q <= arbb_pkg::sat_coord(arbb_pkg::widen(in_data_i.rect_top)
                                  + arbb_pkg::widen(in_data_i.rect_height));
    end
  end

  // Eight exact products: each coefficient against both values of its input axis.
  always_ff @(posedge clk_i) begin
    if (adv[StgMul]) begin
      prod_q[0] <= arbb_pkg::mul_full(coef_xx_q, x0_q);
      prod_q[1] <= arbb_pkg::mul_full(coef_xx_q, x1_q);
      prod_q[2] <= arbb_pkg::mul_full(coef_xy_q, y0_q);
      prod_q[3] <= arbb_pkg::mul_full(coef_xy_q, y1_q);
      prod_q[4] <= arbb_pkg::mul_full(coef_yx_q, x0_q);
      prod_q[5] <= arbb_pkg::mul_full(coef_yx_q, x1_q);
      prod_q[6] <= arbb_pkg::mul_full(coef_yy_q, y0_q);
      prod_q[7] <= arbb_pkg::mul_full(coef_yy_q, y1_q);
    end
  end

  // Floor the fraction away and saturate each term.
  always_ff @(posedge clk_i) begin
    if (adv[StgScale]) begin
      for (int n = 0; n < 8; n++) begin
        term_q[n] <= arbb_pkg::scale_sat(prod_q[n]);
      end
    end
  end

  // Mapped corners; corner 2*i+j uses x value i and y value j.
  always_ff @(posedge clk_i) begin
    if (adv[StgSum]) begin
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          px_q[2*i+j] <= arbb_pkg::sat_coord(arbb_pkg::widen(term_q[i])
                                             + arbb_pkg::widen(term_q[2+j])
                                             + arbb_pkg::widen(offset_x_q));
          py_q[2*i+j] <= arbb_pkg::sat_coord(arbb_pkg::widen(term_q[4+i])
                                             + arbb_pkg::widen(term_q[6+j])
                                             + arbb_pkg::widen(offset_y_q));
        end
      end
    end
  end

  // Reduction to the box in the last three stages.
  assign ext_adv.pair  = adv[StgPair];
  assign ext_adv.total = adv[StgTotal];
  assign ext_adv.span  = adv[StgSpan];

  arbb_extent u_extent (
    .clk_i (clk_i),
    .adv_i (ext_adv),
    .px_i  (px_q),
    .py_i  (py_q),
    .box_o (out_data_o)
  );

endmodule

FILE: rtl/core/arbb_port_check.sv
// Port-level checks for the affine bounding box block, bound to its top level.
module arbb_port_check (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input arbb_pkg::box_t  out_data_o
);

  // No word is offered while reset is applied.
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output word offered during reset");

  // The input only stalls when the pipeline is full and its output is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled with room in the pipeline");

  // A held output word stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output word withdrawn while stalled");

  // A held output word does not change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && out_stall_i) |=> $stable(out_data_o))
    else $error("output word changed while stalled");

endmodule

bind affine_rect_bounding_box arbb_port_check u_port_check (.*);
